>>> src/dhg_pkg.sv
`default_nettype none
package dhg_pkg;

	localparam int COLUMNS_PER_HALF = 64;
	localparam int PAGE_COUNT = 8;
	localparam int HALF_DEPTH = COLUMNS_PER_HALF * PAGE_COUNT;
	localparam int COL_W = $clog2(COLUMNS_PER_HALF);
	localparam int PAGE_W = $clog2(PAGE_COUNT);
	localparam int ADDR_W = PAGE_W + COL_W;
	localparam int BYTE_W = 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] CMD_DISP_MASK = 8'hFE;
	localparam logic [BYTE_W-1:0] CMD_DISP_CODE = 8'h3E;
	localparam logic [BYTE_W-1:0] CMD_COL_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CMD_COL_CODE = 8'h40;
	localparam logic [BYTE_W-1:0] CMD_PAGE_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] CMD_PAGE_CODE = 8'hB8;
	localparam logic [BYTE_W-1:0] STATUS_OFF = 8'h20;
	localparam logic [BYTE_W-1:0] STATUS_ON = 8'h00;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_WR_DATA,
		OP_DISP,
		OP_COLUMN,
		OP_PAGE,
		OP_RD_STATUS,
		OP_RD_DATA
	} op_t;

	typedef struct packed {
		op_t op;
		logic sel_left;
		logic sel_right;
		logic [BYTE_W-1:0] arg;
	} item_t;

	typedef struct packed {
		logic valid;
		item_t item;
	} head_t;

endpackage
`default_nettype wire

>>> src/dual_half_glcd_controller.sv
// A transaction accepted at a clock edge is stored in the queue, then taken by the executing
// side, which registers its result with done; a data read then holds the executing side in a
// wait state to refill its latch. Throughput: one transaction per cycle, save while busy is
// high or a data read waits. A two-entry queue sits between the decoder and the executing
// side; busy rises when it fills. After reset both 512-byte display RAMs are cleared, one
// address a cycle, with busy high. Results are shown for one cycle only; the receiver cannot stall them.
`default_nettype none
module dual_half_glcd_controller (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic kind,
	input wire logic is_data,
	input wire logic select_left,
	input wire logic select_right,
	input wire logic [7:0] bus_byte,
	output logic done,
	output logic [7:0] read_byte
);

	dhg_pkg::head_t head;
	logic full;
	logic pop;
	logic clearing;
	logic push;

	assign busy = full || clearing;
	assign push = start && !busy;

	dhg_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.kind(kind),
		.is_data(is_data),
		.select_left(select_left),
		.select_right(select_right),
		.bus_byte(bus_byte),
		.pop(pop),
		.full(full),
		.head(head)
	);

	dhg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.clearing(clearing),
		.done(done),
		.read_byte(read_byte)
	);

endmodule
`default_nettype wire

>>> src/dhg_ram.sv
`default_nettype none
module dhg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

>>> src/dhg_front.sv
`default_nettype none
module dhg_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic kind,
	input wire logic is_data,
	input wire logic select_left,
	input wire logic select_right,
	input wire logic [dhg_pkg::BYTE_W-1:0] bus_byte,
	input wire logic pop,
	output logic full,
	output dhg_pkg::head_t head
);

	dhg_pkg::item_t item;
	dhg_pkg::item_t queue_q [dhg_pkg::QUEUE_DEPTH];
	logic [dhg_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [dhg_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [dhg_pkg::QCNT_W-1:0] count_q;

	always_comb begin
		item = '0;
		item.arg = bus_byte;
		item.op = dhg_pkg::OP_NOP;
		if (!kind) begin
			item.sel_left = select_left;
			item.sel_right = select_right;
			if (select_left || select_right) begin
				if (is_data) begin
					item.op = dhg_pkg::OP_WR_DATA;
				end else if ((bus_byte & dhg_pkg::CMD_DISP_MASK) == dhg_pkg::CMD_DISP_CODE) begin
					item.op = dhg_pkg::OP_DISP;
				end else if ((bus_byte & dhg_pkg::CMD_COL_MASK) == dhg_pkg::CMD_COL_CODE) begin
					item.op = dhg_pkg::OP_COLUMN;
				end else if ((bus_byte & dhg_pkg::CMD_PAGE_MASK) == dhg_pkg::CMD_PAGE_CODE) begin
					item.op = dhg_pkg::OP_PAGE;
				end
				// The start line command has no effect visible on this bus.
			end
		end else if (select_left || select_right) begin
			// A read is served by one half only, the left one when both are selected.
			item.sel_left = select_left;
			item.sel_right = !select_left;
			item.op = is_data ? dhg_pkg::OP_RD_DATA : dhg_pkg::OP_RD_STATUS;
		end
	end

	assign full = (count_q == dhg_pkg::QCNT_W'(dhg_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.item = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dhg_pkg::QCNT_W'(dhg_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head.valid)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");

endmodule
`default_nettype wire

>>> src/dhg_back.sv
`default_nettype none
module dhg_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire dhg_pkg::head_t head,
	output logic pop,
	output logic clearing,
	output logic done,
	output logic [dhg_pkg::BYTE_W-1:0] read_byte
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RDWAIT = 2'b10
	} state_t;

	state_t state_q;
	logic clearing_q;
	logic [dhg_pkg::ADDR_W-1:0] clr_addr_q;
	logic [dhg_pkg::PAGE_W-1:0] page_q [2];
	logic [dhg_pkg::COL_W-1:0] col_q [2];
	logic enabled_q [2];
	logic [dhg_pkg::BYTE_W-1:0] latch_q [2];
	logic rd_half_q;
	logic done_q;
	logic [dhg_pkg::BYTE_W-1:0] read_byte_q;

	logic ram_we [2];
	logic [dhg_pkg::ADDR_W-1:0] ram_addr [2];
	logic [dhg_pkg::BYTE_W-1:0] ram_wdata;
	logic [dhg_pkg::BYTE_W-1:0] ram_rdata [2];
	logic sel [2];
	logic rd_half;
	logic is_wr;

	assign pop = (state_q == ST_IDLE) && !clearing_q && head.valid;
	assign sel[0] = head.item.sel_left;
	assign sel[1] = head.item.sel_right;
	assign rd_half = head.item.sel_right;
	assign is_wr = pop && (head.item.op == dhg_pkg::OP_WR_DATA);
	assign ram_wdata = clearing_q ? '0 : head.item.arg;

	always_comb begin
		for (int h = 0; h < 2; h++) begin
			ram_addr[h] = clearing_q ? clr_addr_q : {page_q[h], col_q[h]};
			ram_we[h] = clearing_q || (is_wr && sel[h]);
		end
	end

	dhg_ram #(.WIDTH(dhg_pkg::BYTE_W), .DEPTH(dhg_pkg::HALF_DEPTH)) u_ram_left (
		.clk(clk),
		.we(ram_we[0]),
		.addr(ram_addr[0]),
		.wdata(ram_wdata),
		.rdata(ram_rdata[0])
	);

	dhg_ram #(.WIDTH(dhg_pkg::BYTE_W), .DEPTH(dhg_pkg::HALF_DEPTH)) u_ram_right (
		.clk(clk),
		.we(ram_we[1]),
		.addr(ram_addr[1]),
		.wdata(ram_wdata),
		.rdata(ram_rdata[1])
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
			done_q <= 1'b0;
			for (int h = 0; h < 2; h++) begin
				page_q[h] <= '0;
				col_q[h] <= '0;
				enabled_q[h] <= 1'b0;
				latch_q[h] <= '0;
			end
		end else begin
			done_q <= pop;
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == dhg_pkg::ADDR_W'(dhg_pkg::HALF_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						for (int h = 0; h < 2; h++) begin
							if (sel[h]) begin
								case (head.item.op) inside
									dhg_pkg::OP_WR_DATA, dhg_pkg::OP_RD_DATA:
										col_q[h] <= col_q[h] + 1'b1;
									dhg_pkg::OP_DISP: enabled_q[h] <= head.item.arg[0];
									dhg_pkg::OP_COLUMN: col_q[h] <= head.item.arg[dhg_pkg::COL_W-1:0];
									dhg_pkg::OP_PAGE: page_q[h] <= head.item.arg[dhg_pkg::PAGE_W-1:0];
									default: ;
								endcase
							end
						end
						if (head.item.op == dhg_pkg::OP_RD_DATA) begin
							state_q <= ST_RDWAIT;
						end
					end
				end
				ST_RDWAIT: begin
					// The RAM word fetched at the data read refills the read-ahead latch.
					latch_q[rd_half_q] <= ram_rdata[rd_half_q];
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_half_q <= rd_half;
			case (head.item.op)
				dhg_pkg::OP_RD_DATA: read_byte_q <= latch_q[rd_half];
				dhg_pkg::OP_RD_STATUS:
					read_byte_q <= enabled_q[rd_half] ? dhg_pkg::STATUS_ON : dhg_pkg::STATUS_OFF;
				default: read_byte_q <= '0;
			endcase
		end
	end

	assign clearing = clearing_q;
	assign done = done_q;
	assign read_byte = read_byte_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == ST_IDLE && !clearing_q))
		else $error("item taken while back end is occupied");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.item.op == dhg_pkg::OP_RD_DATA) |=> (state_q == ST_RDWAIT))
		else $error("data read did not wait for the RAM word");
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> $past(pop))
		else $error("result without an executed transaction");

endmodule
`default_nettype wire

>>> dv/testbench.sv
`default_nettype none
module testbench;

	localparam logic BUS_WRITE = 1'b0;
	localparam logic BUS_READ = 1'b1;
	localparam logic SEL_INSTR = 1'b0;
	localparam logic SEL_DATA = 1'b1;
	localparam logic [7:0] START_LINE_CODE = 8'hC0;
	localparam logic [7:0] WRITE_ECHO = 8'h00;
	localparam logic [7:0] NO_HALF_READ = 8'h00;
	localparam logic [7:0] CMD_DISP_ON = dhg_pkg::CMD_DISP_CODE | 8'h01;
	localparam logic CHECKED = 1'b1;
	localparam logic PREDICTED = 1'b0;
	localparam int RANDOM_ACCESSES = 1350;
	localparam int STALL_LIMIT = 2000;
	localparam int DIRECTED_ROWS = 25;

	typedef struct packed {
		logic kind;
		logic is_data;
		logic sel_left;
		logic sel_right;
		logic [7:0] bus_byte;
		logic fixed;
		logic [7:0] fixed_byte;
	} glcd_access_t;

	// The fixed byte is used where the answer is obvious; otherwise the shadow model decides.
	localparam glcd_access_t DIRECTED [DIRECTED_ROWS] = '{
		{BUS_READ, SEL_INSTR, 1'b1, 1'b0, 8'h00, CHECKED, dhg_pkg::STATUS_OFF},
		{BUS_READ, SEL_DATA, 1'b1, 1'b0, 8'hFF, CHECKED, 8'h00},
		{BUS_READ, SEL_DATA, 1'b0, 1'b0, 8'h00, CHECKED, NO_HALF_READ},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, CMD_DISP_ON, CHECKED, WRITE_ECHO},
		{BUS_READ, SEL_INSTR, 1'b0, 1'b1, 8'hFF, CHECKED, dhg_pkg::STATUS_ON},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'hBF, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'h7F, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_DATA, 1'b1, 1'b1, 8'hFF, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_DATA, 1'b1, 1'b0, 8'h00, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'h80, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'h10, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'h00, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b1, 8'hFF, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b0, 1'b1, 8'hC0, CHECKED, WRITE_ECHO},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b0, 8'h7F, CHECKED, WRITE_ECHO},
		{BUS_READ, SEL_DATA, 1'b1, 1'b1, 8'h00, PREDICTED, 8'h00},
		{BUS_READ, SEL_DATA, 1'b1, 1'b1, 8'hFF, PREDICTED, 8'h00},
		{BUS_READ, SEL_DATA, 1'b1, 1'b0, 8'h00, PREDICTED, 8'h00},
		{BUS_WRITE, SEL_INSTR, 1'b1, 1'b0, dhg_pkg::CMD_DISP_CODE, CHECKED, WRITE_ECHO},
		{BUS_READ, SEL_INSTR, 1'b1, 1'b1, 8'h00, CHECKED, dhg_pkg::STATUS_OFF},
		{BUS_READ, SEL_INSTR, 1'b0, 1'b0, 8'hFF, CHECKED, NO_HALF_READ},
		{BUS_WRITE, SEL_INSTR, 1'b0, 1'b1, dhg_pkg::CMD_COL_CODE, CHECKED, WRITE_ECHO},
		{BUS_READ, SEL_DATA, 1'b0, 1'b1, 8'h00, PREDICTED, 8'h00},
		{BUS_READ, SEL_DATA, 1'b0, 1'b1, 8'hFF, PREDICTED, 8'h00},
		{BUS_WRITE, SEL_DATA, 1'b0, 1'b0, 8'hA5, CHECKED, WRITE_ECHO}
	};

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic kind = 1'b0;
	logic is_data = 1'b0;
	logic select_left = 1'b0;
	logic select_right = 1'b0;
	logic [7:0] bus_byte = 8'h00;
	logic busy;
	logic done;
	logic [7:0] read_byte;

	// Shadow copy of both halves of the panel.
	logic [7:0] half_ram [2][dhg_pkg::HALF_DEPTH];
	logic [dhg_pkg::PAGE_W-1:0] page_q [2];
	logic [dhg_pkg::COL_W-1:0] column_q [2];
	logic [dhg_pkg::COL_W-1:0] start_line_q [2];
	logic display_on_q [2];
	logic [7:0] read_ahead_q [2];

	glcd_access_t access_q[$];
	logic [7:0] read_byte_q[$];
	int mismatches = 0;
	int stall_cycles = 0;

	dual_half_glcd_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.is_data(is_data),
		.select_left(select_left),
		.select_right(select_right),
		.bus_byte(bus_byte),
		.done(done),
		.read_byte(read_byte)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] predict_read_byte(glcd_access_t a);
		logic [7:0] rb;
		logic [7:0] b;
		int h;
		rb = 8'h00;
		b = a.bus_byte;
		if (a.kind == BUS_WRITE) begin
			for (h = 0; h < 2; h++) begin
				if ((h == 0) ? a.sel_left : a.sel_right) begin
					if (a.is_data == SEL_DATA) begin
						half_ram[h][{page_q[h], column_q[h]}] = b;
						column_q[h] = column_q[h] + 1'b1;
					end else if ((b & dhg_pkg::CMD_DISP_MASK) == dhg_pkg::CMD_DISP_CODE) begin
						display_on_q[h] = b[0];
					end else if ((b & dhg_pkg::CMD_COL_MASK) == dhg_pkg::CMD_COL_CODE) begin
						column_q[h] = b[dhg_pkg::COL_W-1:0];
					end else if ((b & dhg_pkg::CMD_PAGE_MASK) == dhg_pkg::CMD_PAGE_CODE) begin
						page_q[h] = b[dhg_pkg::PAGE_W-1:0];
					end else if ((b & dhg_pkg::CMD_COL_MASK) == START_LINE_CODE) begin
						start_line_q[h] = b[dhg_pkg::COL_W-1:0];
					end
				end
			end
		end else if (a.sel_left || a.sel_right) begin
			// With both halves selected only the left half answers.
			h = a.sel_left ? 0 : 1;
			if (a.is_data == SEL_DATA) begin
				rb = read_ahead_q[h];
				read_ahead_q[h] = half_ram[h][{page_q[h], column_q[h]}];
				column_q[h] = column_q[h] + 1'b1;
			end else begin
				rb = display_on_q[h] ? dhg_pkg::STATUS_ON : dhg_pkg::STATUS_OFF;
			end
		end
		return rb;
	endfunction

	function automatic glcd_access_t bus_access(logic k, logic d, logic [1:0] sel,
			logic [7:0] b);
		glcd_access_t a;
		a = '0;
		a.kind = k;
		a.is_data = d;
		a.sel_left = sel[1];
		a.sel_right = sel[0];
		a.bus_byte = b;
		a.fixed = PREDICTED;
		return a;
	endfunction

	function automatic glcd_access_t random_access();
		logic [1:0] sel;
		logic [7:0] b;
		sel = 2'($urandom_range(0, 3));
		b = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 99)) inside
			[0:29]: return bus_access(BUS_WRITE, SEL_DATA, sel, b);
			[30:54]: return bus_access(BUS_READ, SEL_DATA,
				($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3)), b);
			[55:64]: return bus_access(BUS_READ, SEL_INSTR, sel, b);
			[65:74]: return bus_access(BUS_WRITE, SEL_INSTR, sel,
				dhg_pkg::CMD_COL_CODE | (b & 8'h3F));
			[75:82]: return bus_access(BUS_WRITE, SEL_INSTR, sel,
				dhg_pkg::CMD_PAGE_CODE | (b & 8'h07));
			[83:86]: return bus_access(BUS_WRITE, SEL_INSTR, sel,
				dhg_pkg::CMD_DISP_CODE | (b & 8'h01));
			[87:90]: return bus_access(BUS_WRITE, SEL_INSTR, sel, START_LINE_CODE | b);
			default: return bus_access(BUS_WRITE, SEL_INSTR, sel, b);
		endcase
	endfunction

	// A run of data written at one place, then read back after a dummy read.
	task automatic queue_readback();
		logic [1:0] sel;
		logic [7:0] column_cmd;
		int n;
		sel = 2'($urandom_range(1, 3));
		n = $urandom_range(1, 12);
		column_cmd = dhg_pkg::CMD_COL_CODE | 8'($urandom_range(0, 63));
		access_q.push_back(bus_access(BUS_WRITE, SEL_INSTR, sel,
			dhg_pkg::CMD_PAGE_CODE | 8'($urandom_range(0, 7))));
		access_q.push_back(bus_access(BUS_WRITE, SEL_INSTR, sel, column_cmd));
		repeat (n) access_q.push_back(bus_access(BUS_WRITE, SEL_DATA, sel,
			8'($urandom_range(0, 255))));
		access_q.push_back(bus_access(BUS_WRITE, SEL_INSTR, sel, column_cmd));
		repeat (n + 1) access_q.push_back(bus_access(BUS_READ, SEL_DATA, sel,
			8'($urandom_range(0, 255))));
	endtask

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		$display("%0t: %s: read_byte 0x%02h, expected 0x%02h", $time, what, got, want);
	endtask

	// One transaction: driven on the falling edge, held until the block takes it.
	task automatic drive_access(glcd_access_t a);
		logic [7:0] predicted;
		@(negedge clk);
		start <= 1'b1;
		kind <= a.kind;
		is_data <= a.is_data;
		select_left <= a.sel_left;
		select_right <= a.sel_right;
		bus_byte <= a.bus_byte;
		do @(posedge clk); while (busy);
		predicted = predict_read_byte(a);
		read_byte_q.push_back(a.fixed ? a.fixed_byte : predicted);
	endtask

	task automatic idle_bus(int cycles);
		@(negedge clk);
		start <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (read_byte_q.size() == 0)
				report_mismatch("result with no transaction pending", read_byte, 8'h00);
			else if (read_byte !== read_byte_q[0])
				report_mismatch("wrong result", read_byte, read_byte_q.pop_front());
			else
				void'(read_byte_q.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int burst;
		for (int h = 0; h < 2; h++) begin
			for (int i = 0; i < dhg_pkg::HALF_DEPTH; i++)
				half_ram[h][i] = 8'h00;
			page_q[h] = '0;
			column_q[h] = '0;
			start_line_q[h] = '0;
			display_on_q[h] = 1'b0;
			read_ahead_q[h] = 8'h00;
		end
		for (int i = 0; i < DIRECTED_ROWS; i++)
			access_q.push_back(DIRECTED[i]);
		while (access_q.size() < DIRECTED_ROWS + RANDOM_ACCESSES) begin
			if ($urandom_range(0, 9) < 4)
				queue_readback();
			else
				access_q.push_back(random_access());
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (access_q.size() > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && access_q.size() > 0) begin
				drive_access(access_q.pop_front());
				burst--;
			end
			if ($urandom_range(0, 3) != 0)
				idle_bus($urandom_range(1, 6));
		end
		idle_bus(1);

		while (read_byte_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
